[design/mphm_pkg.sv]
`timescale 1ns / 1ps
package mphm_pkg;

  localparam int NUM_PATTERNS_DEF    = 8;
  localparam int MAX_PATTERN_LEN_DEF = 16;

  // widest values the parameters may take
  localparam int SLOT_W_MAX = 6;
  localparam int LEN_W_MAX  = 7;

  typedef enum logic [1:0] {
    KIND_LINE_BYTE = 2'd0,
    KIND_PAT_BYTE  = 2'd1,
    KIND_PAT_LEN   = 2'd2,
    KIND_RSVD      = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_RESOLVE = 2'd1,
    ST_EMIT    = 2'd2
  } state_e;

  // first-hit record handed along the row of pattern cells
  typedef struct packed {
    logic                  hit;
    logic [SLOT_W_MAX-1:0] slot;
    logic [LEN_W_MAX-1:0]  len;
  } hit_t;

endpackage

[design/mphm_cell.sv]
`timescale 1ns / 1ps
module mphm_cell import mphm_pkg::*; #(
  parameter int IDX     = 0,
  parameter int MAX_LEN = MAX_PATTERN_LEN_DEF,
  parameter int LW      = $clog2(MAX_LEN + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    wr_byte_i,
  input  logic                    wr_len_i,
  input  logic [3:0]              offset_i,
  input  logic [7:0]              byte_i,
  input  logic [LW-1:0]           len_i,
  input  logic                    search_en_i,
  input  logic [MAX_LEN-1:0][7:0] window_i,
  input  logic [LW-1:0]           count_i,
  input  hit_t                    hit_i,
  output hit_t                    hit_o
);

  logic [MAX_LEN-1:0][7:0] pat_q;
  logic [LW-1:0]           len_q;
  logic                    match;

  always_ff @(posedge clk_i) begin
    if (wr_byte_i) begin
      for (int i = 0; i < MAX_LEN; i++) begin
        if (i == int'(offset_i)) pat_q[i] <= byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (wr_len_i) begin
      len_q <= len_i;
    end
  end

  always_comb begin
    match = search_en_i && (len_q != '0) && (len_q <= count_i);
    for (int i = 0; i < MAX_LEN; i++) begin
      if ((i < int'(len_q)) && (pat_q[i] != window_i[i])) match = 1'b0;
    end
  end

  // an earlier slot keeps priority
  always_comb begin
    hit_o = hit_i;
    if (!hit_i.hit && match) begin
      hit_o.hit  = 1'b1;
      hit_o.slot = SLOT_W_MAX'(IDX);
      hit_o.len  = LEN_W_MAX'(len_q);
    end
  end

endmodule

[design/multi_pattern_highlight_marker.sv]
`timescale 1ns / 1ps
// a line byte that fills the window or ends the line starts a resolve at its transfer;
// each head of the window passes through the resolve state, then the emit state sends one
// result per byte (a match gives its whole length); the first result goes through the
// resolve and emit states into the output register; a load or a silent line byte stays in idle
// the row of pattern cells compares all slots at once; tready stays low until the last result
// reset clears the window count, slot lengths, slot count and control; pattern bytes are not reset
module multi_pattern_highlight_marker import mphm_pkg::*; #(
  parameter int NUM_PATTERNS    = NUM_PATTERNS_DEF,
  parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [3:0]  cfg_wr_data_i,   // patterns_in_use
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,    // byte_value[7:0], slot[10:8], offset[14:11],
                                       // pattern_length[19:15], zero[23:20]
  input  logic [1:0]  s_axis_tuser,    // kind
  input  logic        s_axis_tlast,    // end_of_line
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,    // out_byte[7:0], in_match[8], match_start[9],
                                       // match_end[10], pattern_index[13:11], line_end[14], zero[15]
  output logic        m_axis_tlast     // last
);

  localparam int LW = $clog2(MAX_PATTERN_LEN + 1);

  state_e state_q, state_d;
  logic [3:0]                      use_q;
  logic [MAX_PATTERN_LEN-1:0][7:0] win_q;
  logic [LW-1:0]                   count_q, count_d;
  logic                            eol_q;
  logic                            hit_q;
  logic [2:0]                      slot_q;
  logic [LW-1:0]                   rem_q;
  logic                            first_q;
  logic                            ovalid_q;
  logic [15:0]                     odata_q;
  logic                            olast_q;

  logic       in_xfer, emit_go, is_line, wr_byte, wr_len;
  logic [7:0] in_byte;
  logic [2:0] in_slot;
  logic [3:0] in_off;
  logic [4:0] in_plen;
  logic [LW-1:0] len_sat;
  logic       final_emit, item_last;
  hit_t       chain [NUM_PATTERNS+1];

  assign in_byte = s_axis_tdata[7:0];
  assign in_slot = s_axis_tdata[10:8];
  assign in_off  = s_axis_tdata[14:11];
  assign in_plen = s_axis_tdata[19:15];

  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign is_line = in_xfer && (kind_e'(s_axis_tuser) == KIND_LINE_BYTE);
  assign wr_byte = in_xfer && (kind_e'(s_axis_tuser) == KIND_PAT_BYTE)
                   && (int'(in_slot) < NUM_PATTERNS) && (int'(in_off) < MAX_PATTERN_LEN);
  assign wr_len  = in_xfer && (kind_e'(s_axis_tuser) == KIND_PAT_LEN)
                   && (int'(in_slot) < NUM_PATTERNS);
  assign len_sat = (int'(in_plen) > MAX_PATTERN_LEN) ? LW'(MAX_PATTERN_LEN) : LW'(in_plen);

  assign chain[0] = '0;

  for (genvar g = 0; g < NUM_PATTERNS; g++) begin : g_cell
    mphm_cell #(
      .IDX     (g),
      .MAX_LEN (MAX_PATTERN_LEN),
      .LW      (LW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .wr_byte_i   (wr_byte && (int'(in_slot) == g)),
      .wr_len_i    (wr_len && (int'(in_slot) == g)),
      .offset_i    (in_off),
      .byte_i      (in_byte),
      .len_i       (len_sat),
      .search_en_i (g < int'(use_q)),
      .window_i    (win_q),
      .count_i     (count_q),
      .hit_i       (chain[g]),
      .hit_o       (chain[g+1])
    );
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    emit_go       = (state_q == ST_EMIT) && (!ovalid_q || m_axis_tready);
  end

  assign final_emit = (rem_q == LW'(1));
  assign item_last  = final_emit && (!eol_q || count_q == LW'(1));

  always_comb begin
    count_d = count_q;
    if (is_line && int'(count_q) < MAX_PATTERN_LEN) count_d = count_q + LW'(1);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (is_line && (s_axis_tlast || int'(count_d) == MAX_PATTERN_LEN)) state_d = ST_RESOLVE;
      end
      ST_RESOLVE: state_d = ST_EMIT;
      ST_EMIT: begin
        if (emit_go && final_emit) state_d = item_last ? ST_IDLE : ST_RESOLVE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      use_q    <= '0;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr_en_i) begin
        use_q <= (int'(cfg_wr_data_i) > NUM_PATTERNS) ? 4'(NUM_PATTERNS) : cfg_wr_data_i;
      end
      if (emit_go) begin
        count_q  <= count_q - LW'(1);
        ovalid_q <= 1'b1;
      end else begin
        count_q <= count_d;
        if (m_axis_tready) ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_line) begin
      eol_q <= s_axis_tlast;
      for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
        if (LW'(i) == count_q) win_q[i] <= in_byte;
      end
    end
    if (state_q == ST_RESOLVE) begin
      hit_q   <= chain[NUM_PATTERNS].hit;
      slot_q  <= chain[NUM_PATTERNS].slot[2:0];
      rem_q   <= chain[NUM_PATTERNS].hit ? LW'(chain[NUM_PATTERNS].len) : LW'(1);
      first_q <= 1'b1;
    end
    if (emit_go) begin
      for (int i = 0; i < MAX_PATTERN_LEN - 1; i++) win_q[i] <= win_q[i+1];
      rem_q   <= rem_q - LW'(1);
      first_q <= 1'b0;
      odata_q <= {1'b0, item_last && eol_q, hit_q ? slot_q : 3'd0,
                  hit_q && final_emit, hit_q && first_q, hit_q, win_q[0]};
      olast_q <= item_last;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tlast  = olast_q;

endmodule

[tb/multi_pattern_highlight_marker_test.sv]
`timescale 1ns / 1ps
module multi_pattern_highlight_marker_test;
  import mphm_pkg::*;

  localparam int NPAT = 8;
  localparam int PLEN = 16;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic       line_end;
    logic [2:0] pattern_index;
    logic       match_end;
    logic       match_start;
    logic       in_match;
    logic [7:0] out_byte;
    logic       last;
  } mark_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_wr_en_i = 1'b0;
  logic [3:0]  cfg_wr_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = KIND_LINE_BYTE;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  multi_pattern_highlight_marker dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_wr_en_i(cfg_wr_en_i), .cfg_wr_data_i(cfg_wr_data_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // own copy of the marker state
  logic [7:0] pat_bytes [NPAT][PLEN];
  bit         pat_written [NPAT][PLEN];
  logic [4:0] pat_len [NPAT];
  logic [7:0] window [PLEN];
  int         win_count;
  int         slots_searched;

  mark_t expected_marks[$];
  int    errors = 0;
  int    cycles = 0;
  int    stall_left = 0;
  bit    quiet = 1'b0;

  task automatic resolve_head(ref mark_t marks[$]);
    int s;
    int len;
    bit hit;
    mark_t m;
    hit = 1'b0;
    len = 1;
    for (s = 0; s < slots_searched && !hit; s++) begin
      if (pat_len[s] != 0 && pat_len[s] <= win_count) begin
        hit = 1'b1;
        for (int i = 0; i < pat_len[s]; i++)
          if (pat_bytes[s][i] != window[i]) hit = 1'b0;
        if (hit) len = pat_len[s];
      end
    end
    if (hit) s--;
    for (int i = 0; i < len; i++) begin
      m = '0;
      m.out_byte = window[i];
      if (hit) begin
        m.in_match = 1'b1;
        m.match_start = (i == 0);
        m.match_end = (i + 1 == len);
        m.pattern_index = s[2:0];
      end
      marks.push_back(m);
    end
    for (int i = 0; i + len < win_count; i++) window[i] = window[i + len];
    win_count -= len;
  endtask

  task automatic predict_marks(kind_e kind, logic [7:0] b, logic eol, logic [2:0] slot,
                               logic [3:0] off, logic [4:0] plen);
    mark_t marks[$];
    case (kind)
      KIND_PAT_BYTE: begin
        pat_bytes[slot][off] = b;
        pat_written[slot][off] = 1'b1;
      end
      KIND_PAT_LEN: pat_len[slot] = (plen > PLEN) ? 5'(PLEN) : plen;
      KIND_LINE_BYTE: begin
        if (win_count < PLEN) begin
          window[win_count] = b;
          win_count++;
        end
        if (eol) begin
          while (win_count > 0) resolve_head(marks);
        end else if (win_count == PLEN) begin
          resolve_head(marks);
        end
        if (marks.size() > 0) begin
          marks[$].last = 1'b1;
          marks[$].line_end = eol;
        end
        foreach (marks[i]) expected_marks.push_back(marks[i]);
      end
      default: ;
    endcase
  endtask

  // tvalid stays high after a transfer until the next call changes it at this falling edge
  task automatic send_item(kind_e kind, logic [7:0] b, logic eol, logic [2:0] slot,
                           logic [3:0] off, logic [4:0] plen);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tlast  <= eol;
    s_axis_tdata  <= {4'b0, plen, off, slot, b};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_marks(kind, b, eol, slot, off, plen);
    @(negedge clk_i);
  endtask

  task automatic load_pattern(int slot, int len, logic [7:0] body [PLEN]);
    for (int i = 0; i < len; i++)
      send_item(KIND_PAT_BYTE, body[i], 1'b0, slot[2:0], i[3:0], 5'd0);
    send_item(KIND_PAT_LEN, 8'd0, 1'b0, slot[2:0], 4'd0, len[4:0]);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (expected_marks.size() > 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_slots_searched(int n);
    drain();
    cfg_wr_en_i <= 1'b1;
    cfg_wr_data_i <= n[3:0];
    @(negedge clk_i);
    cfg_wr_en_i <= 1'b0;
    slots_searched = (n > NPAT) ? NPAT : n;
  endtask

  // random text over a small alphabet so pattern hits are common
  function automatic logic [7:0] text_byte();
    return ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(8'h61, 8'h64));
  endfunction

  task automatic send_line(int n);
    for (int i = 0; i < n; i++)
      send_item(KIND_LINE_BYTE, text_byte(), i == n - 1, 3'($urandom), 4'($urandom),
                5'($urandom));
  endtask

  task automatic test_directed;
    logic [7:0] body [PLEN];
    for (int i = 0; i < PLEN; i++) body[i] = 8'h61;
    // no patterns searched: plain bytes, window fill and line flush
    send_item(KIND_LINE_BYTE, 8'h00, 1'b1, 3'd7, 4'd15, 5'd31);
    for (int i = 0; i < 18; i++) send_item(KIND_LINE_BYTE, 8'hff, 1'b0, 3'd0, 4'd0, 5'd0);
    send_item(KIND_LINE_BYTE, 8'h5a, 1'b1, 3'd0, 4'd0, 5'd0);
    // reserved kind is ignored
    send_item(KIND_RSVD, 8'hff, 1'b1, 3'd7, 4'd15, 5'd31);
    // full length pattern in slot 7, oversize length saturates
    for (int i = 0; i < PLEN; i++)
      send_item(KIND_PAT_BYTE, 8'h61, 1'b0, 3'd7, i[3:0], 5'd0);
    send_item(KIND_PAT_LEN, 8'd0, 1'b0, 3'd7, 4'd0, 5'd31);
    body[0] = 8'h61; body[1] = 8'h62;
    load_pattern(0, 2, body);
    send_item(KIND_PAT_LEN, 8'd0, 1'b0, 3'd1, 4'd0, 5'd0);
    set_slots_searched(15);
    for (int i = 0; i < 17; i++) send_item(KIND_LINE_BYTE, 8'h61, i == 16, 3'd0, 4'd0, 5'd0);
    send_item(KIND_LINE_BYTE, 8'h61, 1'b0, 3'd0, 4'd0, 5'd0);
    send_item(KIND_LINE_BYTE, 8'h62, 1'b1, 3'd0, 4'd0, 5'd0);
  endtask

  task automatic test_random_text;
    logic [7:0] body [PLEN];
    int len;
    for (int phase = 0; phase < 4; phase++) begin
      for (int s = 0; s < NPAT; s++) begin
        len = ($urandom_range(0, 7) == 0) ? 0 :
              ($urandom_range(0, 5) == 0) ? PLEN : $urandom_range(1, 4);
        for (int i = 0; i < PLEN; i++) body[i] = text_byte();
        if ($urandom_range(0, 2) == 0) load_pattern(s, len, body);
      end
      set_slots_searched(phase == 0 ? 0 : phase == 1 ? 8 : $urandom_range(0, 15));
      for (int l = 0; l < 5; l++) send_line($urandom_range(1, 24));
      // pattern rewrite between lines, only of a byte already written, keeping lengths within written bytes
      if (pat_written[2][0]) send_item(KIND_PAT_BYTE, text_byte(), 1'b0, 3'd2, 4'd0, 5'd0);
      send_item(KIND_RSVD, 8'($urandom), 1'($urandom), 3'($urandom), 4'($urandom),
                5'($urandom));
      send_line($urandom_range(1, 20));
    end
  endtask

  task automatic test_no_idle;
    quiet = 1'b1;
    for (int l = 0; l < 4; l++) send_line($urandom_range(8, 20));
  endtask

  // result checker
  always @(posedge clk_i) begin
    mark_t got;
    mark_t want;
    cycles++;
    if (m_axis_tvalid && m_axis_tready) begin
      got = mark_t'({m_axis_tdata[14:0], m_axis_tlast});
      if (expected_marks.size() == 0) begin
        $display("%0t unexpected result expected none actual %h", $time, got);
        errors++;
      end else begin
        want = expected_marks.pop_front();
        if (got !== want) begin
          $display("%0t mismatch expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // output stalls come in bursts
  always @(negedge clk_i) begin
    if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    foreach (pat_len[i]) pat_len[i] = '0;
    foreach (pat_written[s, i]) pat_written[s][i] = 1'b0;
    win_count = 0;
    slots_searched = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_text();
    test_no_idle();
    drain();
    repeat (20) @(negedge clk_i);
    if (errors == 0 && expected_marks.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
design/mphm_pkg.sv
design/mphm_cell.sv
design/multi_pattern_highlight_marker.sv
tb/multi_pattern_highlight_marker_test.sv
